// ----- hw/rtl/arlp_pkg.sv -----
package arlp_pkg;

    localparam int SAMPLE_WIDTH_DEFAULT = 24;
    localparam int COEF_WIDTH           = 32;
    localparam int FRAC_SHIFT           = 30;

    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 5;
    localparam int REG_IDX_WIDTH  = 3;

    // Register indexes; byte address is four times the index.
    localparam logic [REG_IDX_WIDTH-1:0] REG_COEF_FB_ONE = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_COEF_FB_TWO = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_COEF_INPUT  = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_OFFSET_X    = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_OFFSET_Y    = 3'd4;
    localparam logic [REG_IDX_WIDTH-1:0] REG_OFFSET_Z    = 3'd5;

    localparam logic signed [COEF_WIDTH-1:0] COEF_FB_ONE_RESET = 32'sd2071735488;
    localparam logic signed [COEF_WIDTH-1:0] COEF_FB_TWO_RESET = -32'sd1000494916;
    localparam logic signed [COEF_WIDTH-1:0] COEF_INPUT_RESET  = 32'sd2501237;

    localparam int NUM_AXES = 3;

endpackage

// ----- hw/rtl/accel_axis_remap_lowpass_top.sv -----
// Accelerometer board remap and second-order low-pass. Each input beat carries three signed
// Q7.16 sensor axes in s_tdata and a data-ready flag in s_tuser; beats without the flag are
// taken and discarded. A ready sample is rotated into board axes (x = sensor y, y = minus
// sensor x, z = sensor z), offset per axis and saturated, then filtered as
// y = c0*y1 + c1*y2 + c2*x with Q2.30 coefficients, rounded half up and saturated. The first
// ready sample after reset primes the history and comes out unchanged with m_tuser set. The
// block takes one beat per clock unless m_tready stalls the output. One register holds the
// calibrated sample, one the result; the three multiply-adds of each axis are combinational
// and the history updates as the result is registered. The user must write registers
// through the APB port only while no sample is in flight; the block does not enforce it.
module accel_axis_remap_lowpass_top
    import arlp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_tvalid,
    output logic                      s_tready,
    // raw_x, raw_y, raw_z from bit 0 up, zero filled to whole bytes
    input  logic [8*((3*SAMPLE_WIDTH+7)/8)-1:0] s_tdata,
    // data_ready
    input  logic                      s_tuser,

    output logic                      m_tvalid,
    input  logic                      m_tready,
    // filtered_x, filtered_y, filtered_z from bit 0 up, zero filled to whole bytes
    output logic [8*((3*SAMPLE_WIDTH+7)/8)-1:0] m_tdata,
    // was_priming
    output logic                      m_tuser,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    localparam int W       = SAMPLE_WIDTH;
    localparam int TDATA_W = 8*((3*W+7)/8);
    localparam int PAD_W   = TDATA_W - 3*W;
    localparam int CAL_W   = W + 2;
    localparam int PROD_W  = COEF_WIDTH + W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int SHR_W   = SUM_W - FRAC_SHIFT;

    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_SHIFT - 1);

    // ---------------- configuration registers ----------------
    logic signed [COEF_WIDTH-1:0] coef_fb_one_reg;
    logic signed [COEF_WIDTH-1:0] coef_fb_two_reg;
    logic signed [COEF_WIDTH-1:0] coef_input_reg;
    logic [NUM_AXES-1:0][W-1:0]   offset_reg;

    logic                     cfg_write;
    logic [REG_IDX_WIDTH-1:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[APB_ADDR_WIDTH-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_fb_one_reg <= COEF_FB_ONE_RESET;
            coef_fb_two_reg <= COEF_FB_TWO_RESET;
            coef_input_reg  <= COEF_INPUT_RESET;
            offset_reg      <= '0;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_COEF_FB_ONE: coef_fb_one_reg <= pwdata[COEF_WIDTH-1:0];
                REG_COEF_FB_TWO: coef_fb_two_reg <= pwdata[COEF_WIDTH-1:0];
                REG_COEF_INPUT:  coef_input_reg  <= pwdata[COEF_WIDTH-1:0];
                REG_OFFSET_X:    offset_reg[0]   <= pwdata[W-1:0];
                REG_OFFSET_Y:    offset_reg[1]   <= pwdata[W-1:0];
                REG_OFFSET_Z:    offset_reg[2]   <= pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_COEF_FB_ONE: prdata = APB_DATA_WIDTH'(coef_fb_one_reg);
            REG_COEF_FB_TWO: prdata = APB_DATA_WIDTH'(coef_fb_two_reg);
            REG_COEF_INPUT:  prdata = APB_DATA_WIDTH'(coef_input_reg);
            REG_OFFSET_X:    prdata = APB_DATA_WIDTH'($signed(offset_reg[0]));
            REG_OFFSET_Y:    prdata = APB_DATA_WIDTH'($signed(offset_reg[1]));
            REG_OFFSET_Z:    prdata = APB_DATA_WIDTH'($signed(offset_reg[2]));
            default:         prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    logic cal_valid_reg;
    logic m_valid_reg;
    logic out_free;
    logic advance;
    logic s_accept;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = cal_valid_reg && out_free;
    assign s_tready = !cal_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    // ---------------- remap, offset and saturate ----------------
    logic signed [CAL_W-1:0]    remap_in [NUM_AXES];
    logic [NUM_AXES-1:0][W-1:0] cal_next;
    logic [NUM_AXES-1:0][W-1:0] cal_reg;

    always_comb begin
        remap_in[0] = CAL_W'($signed(s_tdata[2*W-1:W]));
        remap_in[1] = -CAL_W'($signed(s_tdata[W-1:0]));
        remap_in[2] = CAL_W'($signed(s_tdata[3*W-1:2*W]));
    end

    genvar a;
    generate
        for (a = 0; a < NUM_AXES; a++) begin : g_cal
            logic signed [CAL_W-1:0] cal_sum;
            logic                    cal_ovf;

            assign cal_sum  = remap_in[a] + CAL_W'($signed(offset_reg[a]));
            assign cal_ovf  = !(&cal_sum[CAL_W-1:W-1]) && (|cal_sum[CAL_W-1:W-1]);
            assign cal_next[a] = !cal_ovf ? cal_sum[W-1:0] :
                                 (cal_sum[CAL_W-1] ? {1'b1, {(W-1){1'b0}}}
                                                   : {1'b0, {(W-1){1'b1}}});
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_valid_reg <= 1'b0;
        end else if (s_accept) begin
            cal_valid_reg <= s_tuser;
        end else if (advance) begin
            cal_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cal_reg <= cal_next;
        end
    end

    // ---------------- filter stage ----------------
    logic                       primed_reg;
    logic [NUM_AXES-1:0][W-1:0] last_reg;
    logic [NUM_AXES-1:0][W-1:0] older_reg;
    logic [NUM_AXES-1:0][W-1:0] filt_next;
    logic [NUM_AXES-1:0][W-1:0] res_next;
    logic [NUM_AXES-1:0][W-1:0] res_reg;
    logic                       priming_reg;

    generate
        for (a = 0; a < NUM_AXES; a++) begin : g_filt
            logic signed [PROD_W-1:0] prod_one;
            logic signed [PROD_W-1:0] prod_two;
            logic signed [PROD_W-1:0] prod_in;
            logic signed [SUM_W-1:0]  acc;
            logic [SHR_W-1:0]         shr;
            logic                     filt_ovf;

            assign prod_one = PROD_W'(coef_fb_one_reg) * PROD_W'($signed(last_reg[a]));
            assign prod_two = PROD_W'(coef_fb_two_reg) * PROD_W'($signed(older_reg[a]));
            assign prod_in  = PROD_W'(coef_input_reg) * PROD_W'($signed(cal_reg[a]));
            // Adding half an LSB before dropping the fraction rounds halves upwards.
            assign acc = SUM_W'(prod_one) + SUM_W'(prod_two) + SUM_W'(prod_in)
                         + $signed(ROUND_HALF);
            assign shr = acc[SUM_W-1:FRAC_SHIFT];
            assign filt_ovf = !(&shr[SHR_W-1:W-1]) && (|shr[SHR_W-1:W-1]);
            assign filt_next[a] = !filt_ovf ? shr[W-1:0] :
                                  (shr[SHR_W-1] ? {1'b1, {(W-1){1'b0}}}
                                                : {1'b0, {(W-1){1'b1}}});
            assign res_next[a] = primed_reg ? filt_next[a] : cal_reg[a];
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
            last_reg   <= '0;
            older_reg  <= '0;
        end else if (advance) begin
            primed_reg <= 1'b1;
            // The priming sample fills both history taps.
            older_reg  <= primed_reg ? last_reg : cal_reg;
            last_reg   <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg     <= res_next;
            priming_reg <= !primed_reg;
        end
    end

    generate
        if (PAD_W > 0) begin : g_pad
            assign m_tdata = {{PAD_W{1'b0}}, res_reg[2], res_reg[1], res_reg[0]};
        end else begin : g_nopad
            assign m_tdata = {res_reg[2], res_reg[1], res_reg[0]};
        end
    endgenerate

    assign m_tuser = priming_reg;

    // ---------------- assertions ----------------
    a_primed_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        primed_reg |=> primed_reg)
        else $error("primed flag cleared outside reset");

    a_drop_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_tuser && !cal_valid_reg) |=> !cal_valid_reg)
        else $error("beat without data_ready entered the filter stage");

    a_history_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(last_reg) && $stable(older_reg) && $stable(primed_reg)))
        else $error("filter history changed without a result being produced");

    a_priming_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && primed_reg) |=> (m_tvalid && !m_tuser))
        else $error("priming flag set on a filtered result");

endmodule
